FILE: hdl/ltc_pkg.sv
// Shared types, constants and seed table of the lattice tick / hash / consensus block.
// Used by the slot RAM, the sequencing engine and the top level.
package ltc_pkg;

   // Lattice geometry.
   localparam int SLOT_COUNT = 128;
   localparam int SLOT_AW    = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_AW + 1;
   localparam int SUM_W      = 32 + SLOT_AW;
   localparam int SEED_COUNT = 16;
   localparam int SEED_W     = $clog2(SEED_COUNT);

   // Reset values of the configuration registers.
   localparam logic [31:0] CEILING_RESET = 32'hFFFF_0000;
   localparam logic [31:0] FLOOR_RESET   = 32'h0000_0100;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 1'b1;

   // Input modes.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_HASH  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Result kinds.
   localparam logic KIND_DIGEST    = 1'b0;
   localparam logic KIND_CONSENSUS = 1'b1;

   // Number of finalization rounds of the digest.
   localparam int FIN_ROUNDS = 4;

   // The seed table repeats its eight values over the seed period.
   function automatic logic [31:0] seed_word(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         3'd0: w = 32'h0003_3C6F;
         3'd1: w = 32'h0007_DAA6;
         3'd2: w = 32'h002A_5C56;
         3'd3: w = 32'h008F_EFA7;
         3'd4: w = 32'h0058_FDEB;
         3'd5: w = 32'h0110_4689;
         3'd6: w = 32'h03A8_2BC8;
         3'd7: w = 32'h0AAE_C964;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] hash_value;
      logic        locked;
      logic        sticky_consensus;
      logic [31:0] tick_count;
      logic [31:0] ceiling_events;
      logic [31:0] floor_events;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ceiling_limit;
      logic [31:0] floor_limit;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
      logic [31:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
   } ram_rd_type;

endpackage

FILE: hdl/ltc_slot_ram.sv
// Lattice word store: one write port and one read port with registered read data.
// Depends on ltc_pkg for the geometry and port structs.
module ltc_slot_ram
   import ltc_pkg::*;
(
   input  logic        clock,
   input  ram_wr_type  wr,
   input  ram_rd_type  rd,
   output logic [31:0] rd_data
);

   logic [31:0] mem_ff [SLOT_COUNT];
   logic [31:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

FILE: hdl/ltc_engine.sv
// Sequencer of the block: seed fill after reset, tick walk, consensus passes and hash fold.
// Depends on ltc_pkg; drives the ports of ltc_slot_ram.
module ltc_engine
   import ltc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        res_valid,
   input  logic        res_ack,
   output rsp_type     res_data,
   output ram_wr_type  ram_wr,
   output ram_rd_type  ram_rd,
   input  logic [31:0] ram_rd_data
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_TICK  = 3'd2;
   localparam logic [2:0] ST_SUM   = 3'd3;
   localparam logic [2:0] ST_DEV   = 3'd4;
   localparam logic [2:0] ST_CHECK = 3'd5;
   localparam logic [2:0] ST_HASH  = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;
   localparam logic [2:0] ST_OUT   = 3'd0;

   // ST_OUT needs its own code; the state vector is widened by one bit for it.
   localparam logic [3:0] S_INIT  = {1'b0, ST_INIT};
   localparam logic [3:0] S_IDLE  = {1'b0, ST_IDLE};
   localparam logic [3:0] S_TICK  = {1'b0, ST_TICK};
   localparam logic [3:0] S_SUM   = {1'b0, ST_SUM};
   localparam logic [3:0] S_DEV   = {1'b0, ST_DEV};
   localparam logic [3:0] S_CHECK = {1'b0, ST_CHECK};
   localparam logic [3:0] S_HASH  = {1'b0, ST_HASH};
   localparam logic [3:0] S_FIN   = {1'b0, ST_FIN};
   localparam logic [3:0] S_OUT   = {1'b1, ST_OUT};

   localparam logic [CNT_W-1:0]   CNT_END  = CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0]   INIT_END = CNT_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_AW-1:0] POS_LAST = SLOT_AW'(SLOT_COUNT - 1);
   localparam logic [SEED_W-1:0]  SEED_END = SEED_W'(SEED_COUNT - 1);
   localparam logic [1:0]         FIN_END  = 2'(FIN_ROUNDS - 1);

   // Control state.
   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SEED_W-1:0]  seed_ff, seed_in;
   logic [31:0]        tick_ff, tick_in;
   logic [31:0]        ceil_cnt_ff, ceil_cnt_in;
   logic [31:0]        floor_cnt_ff, floor_cnt_in;
   logic               flag_ff, flag_in;
   logic [SLOT_AW-1:0] pos_ff, pos_in;
   logic               open_ff, open_in;

   // Data path registers.
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        word0_ff;
   logic [31:0]        acc_ff, acc_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [1:0]         round_ff, round_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [31:0]        maxdev_ff, maxdev_in;
   rsp_type            res_ff, res_in;

   // Combinational helpers.
   logic               accept;
   logic [CNT_W-1:0]   cnt_dec;
   logic [SLOT_AW-1:0] prev_addr;
   logic [31:0]        init_word;
   logic               ceil_hit;
   logic               floor_hit;
   logic [31:0]        grown;
   logic [31:0]        tick_word;
   logic [31:0]        mean;
   logic [31:0]        dev;
   logic               lock;
   logic [31:0]        hash_base;
   logic [SLOT_AW-1:0] hash_pos;
   logic [31:0]        acc_rot;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign prev_addr = cnt_dec[SLOT_AW-1:0];

   // Seed recurrence of the fill pass.
   assign init_word = ((cnt_ff == '0) ? 32'h0 : (prev_ff << 1) + prev_ff)
                      + seed_word(seed_ff[2:0]);

   // Update rule of one word during a tick.
   assign ceil_hit  = (ram_rd_data >= cfg.ceiling_limit);
   assign grown     = (ram_rd_data << 1) + ram_rd_data + tick_ff;
   assign floor_hit = !ceil_hit && (grown < cfg.floor_limit);
   assign tick_word = ceil_hit ? cfg.ceiling_limit : (floor_hit ? cfg.floor_limit : grown);

   // Consensus: mean of the lattice, deviation of the word read back.
   assign mean = sum_ff[SUM_W-1 -: 32];
   assign dev  = (ram_rd_data > mean) ? ram_rd_data - mean : mean - ram_rd_data;
   assign lock = (maxdev_ff < (mean >> 1));

   // Hash fold: a closed message restarts from word 0 at position 0.
   assign hash_base = open_ff ? acc_ff : word0_ff;
   assign hash_pos  = open_ff ? pos_ff : '0;
   assign acc_rot   = {acc_ff[2:0], acc_ff[31:3]};

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      seed_in      = seed_ff;
      tick_in      = tick_ff;
      ceil_cnt_in  = ceil_cnt_ff;
      floor_cnt_in = floor_cnt_ff;
      flag_in      = flag_ff;
      pos_in       = pos_ff;
      open_in      = open_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      round_in     = round_ff;
      sum_in       = sum_ff;
      maxdev_in    = maxdev_ff;
      res_in       = res_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = prev_addr;
      ram_wr.data  = tick_word;
      ram_rd.en    = 1'b0;
      ram_rd.addr  = cnt_ff[SLOT_AW-1:0];

      unique case (state_ff)
         S_INIT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff[SLOT_AW-1:0];
            ram_wr.data = init_word;
            prev_in     = init_word;
            seed_in     = (seed_ff == SEED_END) ? '0 : seed_ff + SEED_W'(1);
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == INIT_END) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            ram_rd.addr = hash_pos;
            if (accept) begin
               unique case (req_data.mode)
                  MODE_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     cnt_in   = '0;
                     state_in = S_TICK;
                  end
                  MODE_HASH: begin
                     ram_rd.en = 1'b1;
                     byte_in   = req_data.data_byte;
                     last_in   = req_data.last_byte;
                     state_in  = S_HASH;
                  end
                  MODE_QUERY: begin
                     sum_in   = '0;
                     cnt_in   = '0;
                     state_in = S_SUM;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Read word k while word k-1 is written back.
         S_TICK: begin
            ram_rd.en = (cnt_ff != CNT_END);
            if (cnt_ff != '0) begin
               ram_wr.en = 1'b1;
               if (ceil_hit) begin
                  ceil_cnt_in = ceil_cnt_ff + 32'd1;
               end
               if (floor_hit) begin
                  floor_cnt_in = floor_cnt_ff + 32'd1;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_END) begin
               state_in = S_IDLE;
            end
         end

         S_SUM: begin
            ram_rd.en = (cnt_ff != CNT_END);
            if (cnt_ff != '0) begin
               sum_in = sum_ff + SUM_W'(ram_rd_data);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_END) begin
               cnt_in    = '0;
               maxdev_in = '0;
               state_in  = S_DEV;
            end
         end

         S_DEV: begin
            ram_rd.en = (cnt_ff != CNT_END);
            if ((cnt_ff != '0) && (dev > maxdev_ff)) begin
               maxdev_in = dev;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_END) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            flag_in                 = flag_ff | lock;
            res_in                  = '0;
            res_in.result_kind      = KIND_CONSENSUS;
            res_in.locked           = lock;
            res_in.sticky_consensus = flag_ff | lock;
            res_in.tick_count       = tick_ff;
            res_in.ceiling_events   = ceil_cnt_ff;
            res_in.floor_events     = floor_cnt_ff;
            state_in                = S_OUT;
         end

         S_HASH: begin
            acc_in  = (hash_base << 1) + hash_base + {24'h0, byte_ff} + ram_rd_data;
            pos_in  = (hash_pos == POS_LAST) ? '0 : hash_pos + SLOT_AW'(1);
            open_in = !last_ff;
            if (last_ff) begin
               round_in = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end

         // One rotate-and-add round per cycle.
         S_FIN: begin
            acc_in   = acc_rot + word0_ff;
            round_in = round_ff + 2'd1;
            if (round_ff == FIN_END) begin
               res_in             = '0;
               res_in.result_kind = KIND_DIGEST;
               res_in.hash_value  = acc_rot + word0_ff;
               state_in           = S_OUT;
            end
         end

         S_OUT: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         seed_ff      <= '0;
         tick_ff      <= '0;
         ceil_cnt_ff  <= '0;
         floor_cnt_ff <= '0;
         flag_ff      <= 1'b0;
         pos_ff       <= '0;
         open_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         seed_ff      <= seed_in;
         tick_ff      <= tick_in;
         ceil_cnt_ff  <= ceil_cnt_in;
         floor_cnt_ff <= floor_cnt_in;
         flag_ff      <= flag_in;
         pos_ff       <= pos_in;
         open_ff      <= open_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      prev_ff   <= prev_in;
      acc_ff    <= acc_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      round_ff  <= round_in;
      sum_ff    <= sum_in;
      maxdev_ff <= maxdev_in;
      res_ff    <= res_in;
   end

   // Copy of word 0, kept current on every write to that address.
   always_ff @(posedge clock) begin
      if (ram_wr.en && (ram_wr.addr == '0)) begin
         word0_ff <= ram_wr.data;
      end
   end

   assign res_valid = (state_ff == S_OUT);
   assign res_data  = res_ff;

   // A tick transaction advances the tick counter by exactly one.
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.mode == MODE_TICK)) |=> (tick_ff == $past(tick_ff) + 32'd1))
      else $error("tick counter did not advance by one");

   // In the tick walk the write-back never hits the word being read.
   a_walk_no_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_wr.en && ram_rd.en && (state_ff == S_TICK)) |-> (ram_wr.addr != ram_rd.addr))
      else $error("tick walk read and write collided");

   // One word is either clamped or raised, never both.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      (ceil_cnt_ff != $past(ceil_cnt_ff)) |-> $stable(floor_cnt_ff))
      else $error("ceiling and floor counted in the same cycle");

   // A locked answer always carries the sticky flag.
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res_data.result_kind == KIND_CONSENSUS) && res_data.locked)
      |-> (res_data.sticky_consensus && flag_ff))
      else $error("locked answer without sticky flag");

endmodule

FILE: hdl/lattice_tick_hash_consensus.sv
// Top level of the lattice tick / hash / consensus block: registers, output stage, wiring.
// Depends on ltc_pkg, ltc_slot_ram and ltc_engine.
//
// Usage: one transaction on the req_ channel carries a mode, a message byte and a last flag.
// A tick transaction gives no result; a hash byte gives a digest on rsp_ only when it is
// marked last; a consensus query always gives one answer. Mode 3 is taken and dropped.
// The csr_ port writes ceiling_limit (index 0) and floor_limit (index 1); the user writes
// them only while idle; the block itself does not enforce it. With N = 128 lattice words
// in one single-port-read memory, a tick reads one word and writes one back per cycle,
// a hash byte is folded into the digest, a last hash byte adds four finalization rounds,
// and a consensus query makes a sum pass, then a deviation pass, before the result.
// One transaction is worked on at a time; req_stall is low only while the engine is idle.
// After reset the lattice is filled with its seed sequence, one word per cycle, all N words,
// with req_stall high; configuration writes are taken during that time.
// Results leave through an output register. The engine goes back to idle as soon as that
// register takes the result, so a new transaction is accepted while rsp_stall holds the
// previous result; a second result then waits in the engine until the register frees.
module lattice_tick_hash_consensus
   import ltc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic        eng_valid;
   rsp_type     eng_data;
   logic        rsp_load;
   ram_wr_type  ram_wr;
   ram_rd_type  ram_rd;
   logic [31:0] ram_rd_data;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CEILING: cfg_in.ceiling_limit = csr_wdata;
            CSR_FLOOR:   cfg_in.floor_limit   = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ceiling_limit <= CEILING_RESET;
         cfg_ff.floor_limit   <= FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: loads an engine result when empty or when its held result is taken.
   assign rsp_load = eng_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= eng_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lattice memory.
   ltc_slot_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   // Sequencer.
   ltc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .res_valid   (eng_valid),
      .res_ack     (rsp_load),
      .res_data    (eng_data),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

endmodule
